// ----- rtl/core/lcdseq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, constants and the microcode control store of the
// character LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    // Request function codes
    localparam logic [2:0] FUNC_CMD   = 3'd0;
    localparam logic [2:0] FUNC_DATA  = 3'd1;
    localparam logic [2:0] FUNC_INIT  = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_GOTO  = 3'd4;

    // Configuration registers, in index order
    localparam int          NREGS    = 7;
    localparam int          REG_W    = 16;
    localparam int          IDX_W    = 3;
    localparam logic [2:0]  H_PULSE  = 3'd0;
    localparam logic [2:0]  H_EXEC   = 3'd1;
    localparam logic [2:0]  H_CLEAR  = 3'd2;
    localparam logic [2:0]  H_GOTO   = 3'd3;
    localparam logic [2:0]  H_POWER  = 3'd4;
    localparam logic [2:0]  H_WAKE1  = 3'd5;
    localparam logic [2:0]  H_WAKE   = 3'd6;

    typedef logic [NREGS-1:0][REG_W-1:0] t_cfg;

    localparam t_cfg CFG_RESET = {16'd150, 16'd10000, 16'd15000, 16'd10000,
                                  16'd15000, 16'd300, 16'd1000};

    // Display geometry
    localparam int DEF_ROWS = 4;
    typedef logic [3:0][7:0] t_row_base;
    localparam t_row_base ROW_BASE = {8'hD4, 8'h94, 8'hC0, 8'h80};

    // Program counter and entry points
    localparam int         PC_W     = 6;
    localparam logic [5:0] PC_BYTE  = 6'd0;
    localparam logic [5:0] PC_GOTO  = 6'd5;
    localparam logic [5:0] PC_CLEAR = 6'd11;
    localparam logic [5:0] PC_INIT  = 6'd17;

    // Nibble source codes
    localparam logic [1:0] NIB_CONST = 2'd0;
    localparam logic [1:0] NIB_HI    = 2'd1;
    localparam logic [1:0] NIB_LO    = 2'd2;

    // One control word per emitted pin state
    typedef struct packed {
        logic            rs_req;     // take register select from the request
        logic            en;         // enable pin level
        logic            byte_const; // use byte_val instead of the request byte
        logic [7:0]      byte_val;
        logic [1:0]      nib_sel;
        logic [3:0]      nib_val;
        logic [2:0]      hold_sel;   // configuration register giving the hold time
        logic            last;       // final state of the request
        logic            jmp;        // continue at tgt instead of pc + 1
        logic [PC_W-1:0] tgt;
    } t_cw;

    // Byte write: two enable pulses, exec wait, then an optional extra wait
    function automatic t_cw byte_step(logic [2:0] k, logic rs, logic bconst,
                                      logic [7:0] b, logic [2:0] wh);
        t_cw cw;
        cw            = '0;
        cw.rs_req     = rs;
        cw.byte_const = bconst;
        cw.byte_val   = b;
        unique case (k)
            3'd0: begin cw.en = 1'b1; cw.nib_sel = NIB_HI; cw.hold_sel = H_PULSE; end
            3'd1: begin cw.en = 1'b0; cw.nib_sel = NIB_HI; cw.hold_sel = H_PULSE; end
            3'd2: begin cw.en = 1'b1; cw.nib_sel = NIB_LO; cw.hold_sel = H_PULSE; end
            3'd3: begin cw.en = 1'b0; cw.nib_sel = NIB_LO; cw.hold_sel = H_PULSE; end
            3'd4: begin cw.en = 1'b0; cw.nib_sel = NIB_LO; cw.hold_sel = H_EXEC;  end
            default: begin cw.en = 1'b0; cw.nib_sel = NIB_LO; cw.hold_sel = wh; end
        endcase
        return cw;
    endfunction

    // Wake nibble: one enable pulse, then a wait
    function automatic t_cw wake_step(logic [2:0] k, logic [3:0] nib, logic [2:0] wh);
        t_cw cw;
        cw         = '0;
        cw.nib_sel = NIB_CONST;
        cw.nib_val = nib;
        unique case (k)
            3'd0:    begin cw.en = 1'b1; cw.hold_sel = H_PULSE; end
            3'd1:    begin cw.en = 1'b0; cw.hold_sel = H_PULSE; end
            default: begin cw.en = 1'b0; cw.hold_sel = wh;      end
        endcase
        return cw;
    endfunction

    // Control store
    function automatic t_cw rom(logic [PC_W-1:0] pc);
        t_cw cw;
        cw = '0;
        priority if (pc <= 6'd4) begin
            cw      = byte_step(pc[2:0], 1'b1, 1'b0, 8'h00, H_EXEC);
            cw.last = (pc == 6'd4);
        end else if (pc <= 6'd10) begin
            cw      = byte_step(3'(pc - PC_GOTO), 1'b0, 1'b0, 8'h00, H_GOTO);
            cw.last = (pc == 6'd10);
        end else if (pc <= 6'd16) begin
            cw      = byte_step(3'(pc - PC_CLEAR), 1'b0, 1'b1, 8'h01, H_CLEAR);
            cw.last = (pc == 6'd16);
        end else if (pc == PC_INIT) begin
            cw.nib_sel  = NIB_CONST;
            cw.hold_sel = H_POWER;
        end else if (pc <= 6'd20) begin
            cw = wake_step(3'(pc - 6'd18), 4'h3, H_WAKE1);
        end else if (pc <= 6'd23) begin
            cw = wake_step(3'(pc - 6'd21), 4'h3, H_WAKE);
        end else if (pc <= 6'd26) begin
            cw = wake_step(3'(pc - 6'd24), 4'h3, H_WAKE);
        end else if (pc <= 6'd28) begin
            cw = wake_step(3'(pc - 6'd27), 4'h2, H_PULSE);
        end else if (pc <= 6'd33) begin
            cw = byte_step(3'(pc - 6'd29), 1'b0, 1'b1, 8'h28, H_EXEC);
        end else if (pc <= 6'd38) begin
            cw = byte_step(3'(pc - 6'd34), 1'b0, 1'b1, 8'h80, H_EXEC);
        end else if (pc <= 6'd43) begin
            cw = byte_step(3'(pc - 6'd39), 1'b0, 1'b1, 8'h0C, H_EXEC);
        end else if (pc <= 6'd48) begin
            cw = byte_step(3'(pc - 6'd44), 1'b0, 1'b1, 8'h06, H_EXEC);
            // finish init with the clear routine
            cw.jmp = (pc == 6'd48);
            cw.tgt = PC_CLEAR;
        end else begin
            cw.last = 1'b1;
        end
        return cw;
    endfunction

endpackage

// ----- rtl/core/lcdseq_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_cfg
// Timing register file: seven 16-bit hold times written through a plain
// write port, reset to the default display timings.
// ----------------------------------------------------------------------------
module lcdseq_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcdseq_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lcdseq_pkg::REG_W-1:0]  i_cfg_data,
    output lcdseq_pkg::t_cfg              o_regs
);

    lcdseq_pkg::t_cfg r_regs;
    lcdseq_pkg::t_cfg n_regs;

    // Write the addressed register; drop writes beyond the list
    always_comb begin
        n_regs = r_regs;
        if (i_cfg_we && (i_cfg_index < lcdseq_pkg::IDX_W'(lcdseq_pkg::NREGS))) begin
            n_regs[i_cfg_index] = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= lcdseq_pkg::CFG_RESET;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

// ----- rtl/core/lcdseq_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_useq
// Microcoded sequencer: step counter over the control store, request byte
// and register select latches, and the pin state output register.
// ----------------------------------------------------------------------------
module lcdseq_useq #(
    parameter int ROWS = lcdseq_pkg::DEF_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcdseq_pkg::t_cfg              i_regs,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_func,
    input  logic [7:0]                    i_value,
    input  logic [2:0]                    i_row,
    input  logic [4:0]                    i_column,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_reg_select,
    output logic                          o_enable_pin,
    output logic [3:0]                    o_nibble,
    output logic [lcdseq_pkg::REG_W-1:0]  o_hold_us,
    output logic                          o_last
);

    localparam int PC_W = lcdseq_pkg::PC_W;

    // Control state
    logic            r_busy,      n_busy;
    logic [PC_W-1:0] r_pc,        n_pc;
    logic            r_out_valid, n_out_valid;
    // Request latches and output payload (no reset)
    logic            r_rs,   n_rs;
    logic [7:0]      r_byte, n_byte;
    logic            r_o_rs, n_o_rs;
    logic            r_o_en, n_o_en;
    logic [3:0]      r_o_nib, n_o_nib;
    logic [lcdseq_pkg::REG_W-1:0] r_o_hold, n_o_hold;
    logic            r_o_last, n_o_last;

    lcdseq_pkg::t_cw cw;
    logic [7:0]      step_byte;
    logic [3:0]      step_nib;
    logic [2:0]      row_c;
    logic [1:0]      row_idx;
    logic [7:0]      addr;
    logic            accept;
    logic            load;

    // Clamp the row and form the cursor address byte
    always_comb begin
        priority if (i_row == 3'd0) begin
            row_c = 3'd1;
        end else if (i_row > 3'(ROWS)) begin
            row_c = 3'(ROWS);
        end else begin
            row_c = i_row;
        end
        row_idx = 2'(row_c - 3'd1);
        addr    = lcdseq_pkg::ROW_BASE[row_idx] + {3'b000, i_column} + 8'hFF;
    end

    // Decode the current control word into pin levels
    always_comb begin
        cw        = lcdseq_pkg::rom(r_pc);
        step_byte = cw.byte_const ? cw.byte_val : r_byte;
        unique case (cw.nib_sel)
            lcdseq_pkg::NIB_HI: step_nib = step_byte[7:4];
            lcdseq_pkg::NIB_LO: step_nib = step_byte[3:0];
            default:            step_nib = cw.nib_val;
        endcase
    end

    assign accept = i_in_valid && !r_busy;
    assign load   = r_busy && (!r_out_valid || !i_out_stall);

    // Advance the step counter and load the output register
    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        n_rs        = r_rs;
        n_byte      = r_byte;
        n_o_rs      = r_o_rs;
        n_o_en      = r_o_en;
        n_o_nib     = r_o_nib;
        n_o_hold    = r_o_hold;
        n_o_last    = r_o_last;

        // drop a transferred result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (load) begin
            n_out_valid = 1'b1;
            n_o_rs      = cw.rs_req & r_rs;
            n_o_en      = cw.en;
            n_o_nib     = step_nib;
            n_o_hold    = i_regs[cw.hold_sel];
            n_o_last    = cw.last;
            if (cw.last) begin
                n_busy = 1'b0;
            end else if (cw.jmp) begin
                n_pc = cw.tgt;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end

        // start a new request; unknown functions give no results
        if (accept) begin
            n_rs   = (i_func == lcdseq_pkg::FUNC_DATA);
            n_byte = (i_func == lcdseq_pkg::FUNC_GOTO) ? addr : i_value;
            unique case (i_func)
                lcdseq_pkg::FUNC_CMD,
                lcdseq_pkg::FUNC_DATA:  begin n_busy = 1'b1; n_pc = lcdseq_pkg::PC_BYTE;  end
                lcdseq_pkg::FUNC_INIT:  begin n_busy = 1'b1; n_pc = lcdseq_pkg::PC_INIT;  end
                lcdseq_pkg::FUNC_CLEAR: begin n_busy = 1'b1; n_pc = lcdseq_pkg::PC_CLEAR; end
                lcdseq_pkg::FUNC_GOTO:  begin n_busy = 1'b1; n_pc = lcdseq_pkg::PC_GOTO;  end
                default:                begin n_busy = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs     <= n_rs;
        r_byte   <= n_byte;
        r_o_rs   <= n_o_rs;
        r_o_en   <= n_o_en;
        r_o_nib  <= n_o_nib;
        r_o_hold <= n_o_hold;
        r_o_last <= n_o_last;
    end

    assign o_in_stall   = r_busy;
    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_o_rs;
    assign o_enable_pin = r_o_en;
    assign o_nibble     = r_o_nib;
    assign o_hold_us    = r_o_hold;
    assign o_last       = r_o_last;

endmodule

// ----- rtl/core/char_lcd_nibble_write_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns display requests into timed pin states for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: func, value,
//   row and column. Output channel (o_out_valid / i_out_stall) carries one pin
//   state per transfer: register select, enable, nibble, hold time in
//   microseconds, and a last flag on the final state of the request.
//   A command or data request gives 5 states, clear 6, goto 6 and init 38;
//   functions 5 to 7 give none.
//   The step counter walks the microcode store one state per cycle; when the
//   receiver stalls, the output register holds its state and the step counter
//   waits. A request holds the input stalled until its last state is loaded;
//   the request transfer sets the step counter, from which the first state is
//   loaded into the output register. A new request is taken in the cycle after
//   the last state is loaded, even while that state still waits in the output
//   register. Timing registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data; the user is to write them only while idle, since the block
//   itself does not enforce it. Writes to an index above 6 are ignored.
//   Reset empties the output register, stops the sequencer and loads the
//   default timings.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer #(
    parameter int ROWS = lcdseq_pkg::DEF_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcdseq_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lcdseq_pkg::REG_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_func,
    input  logic [7:0]                    i_value,
    input  logic [2:0]                    i_row,
    input  logic [4:0]                    i_column,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_reg_select,
    output logic                          o_enable_pin,
    output logic [3:0]                    o_nibble,
    output logic [15:0]                   o_hold_us,
    output logic                          o_last
);

    lcdseq_pkg::t_cfg regs;

    // Timing registers
    lcdseq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (regs)
    );

    // Sequencer and output register
    lcdseq_useq #(
        .ROWS (ROWS)
    ) u_useq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_regs       (regs),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reg_select (o_reg_select),
        .o_enable_pin (o_enable_pin),
        .o_nibble     (o_nibble),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

endmodule

// ----- tb/char_lcd_nibble_write_sequencer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_checker
// Watches the request, pin-state and timing-register ports of the LCD write
// sequencer. It keeps its own copy of the timing registers, expands every
// accepted request into the pin states the display bus should see, and
// compares each pin-state transfer field by field with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_checker #(
    parameter int ROWS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_value,
    input  logic [2:0]  i_row,
    input  logic [4:0]  i_column,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_reg_select,
    input  logic        i_enable_pin,
    input  logic [3:0]  i_nibble,
    input  logic [15:0] i_hold_us,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [15:0] hold;
        logic        last;
    } t_pin_state;

    // DDRAM address of column 1 on each row
    localparam logic [7:0] ROW_START [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    t_pin_state  expected_pins [$];
    logic [15:0] timing [lcdseq_pkg::NREGS];
    logic        bus_rs;
    logic [3:0]  bus_nib;

    // Append one pin state and remember the bus levels for later waits
    task automatic push_pins(input logic rs, input logic en, input logic [3:0] nib,
                             input logic [15:0] hold);
        t_pin_state p;
        p.rs   = rs;
        p.en   = en;
        p.nib  = nib;
        p.hold = hold;
        p.last = 1'b0;
        expected_pins.push_back(p);
        bus_rs  = rs;
        bus_nib = nib;
    endtask

    // Keep the bus as it is with enable low
    task automatic hold_pins(input logic [15:0] hold);
        push_pins(bus_rs, 1'b0, bus_nib, hold);
    endtask

    task automatic strobe_nibble(input logic rs, input logic [3:0] nib);
        push_pins(rs, 1'b1, nib, timing[lcdseq_pkg::H_PULSE]);
        push_pins(rs, 1'b0, nib, timing[lcdseq_pkg::H_PULSE]);
    endtask

    task automatic write_byte_pins(input logic rs, input logic [7:0] b);
        strobe_nibble(rs, b[7:4]);
        strobe_nibble(rs, b[3:0]);
        hold_pins(timing[lcdseq_pkg::H_EXEC]);
    endtask

    task automatic clear_pins();
        write_byte_pins(1'b0, 8'h01);
        hold_pins(timing[lcdseq_pkg::H_CLEAR]);
    endtask

    // Expand one request into its pin states and flag the final one
    task automatic predict_request(input logic [2:0] func, input logic [7:0] value,
                                   input logic [2:0] row, input logic [4:0] column);
        int         start_n;
        logic [2:0] r;
        logic [7:0] addr;
        t_pin_state tail;
        start_n = expected_pins.size();
        bus_rs  = 1'b0;
        bus_nib = 4'h0;
        case (func)
            lcdseq_pkg::FUNC_CMD: begin
                write_byte_pins(1'b0, value);
            end
            lcdseq_pkg::FUNC_DATA: begin
                write_byte_pins(1'b1, value);
            end
            lcdseq_pkg::FUNC_INIT: begin
                push_pins(1'b0, 1'b0, 4'h0, timing[lcdseq_pkg::H_POWER]);
                strobe_nibble(1'b0, 4'h3);
                hold_pins(timing[lcdseq_pkg::H_WAKE1]);
                strobe_nibble(1'b0, 4'h3);
                hold_pins(timing[lcdseq_pkg::H_WAKE]);
                strobe_nibble(1'b0, 4'h3);
                hold_pins(timing[lcdseq_pkg::H_WAKE]);
                strobe_nibble(1'b0, 4'h2);
                write_byte_pins(1'b0, 8'h28);
                write_byte_pins(1'b0, 8'h80);
                write_byte_pins(1'b0, 8'h0C);
                write_byte_pins(1'b0, 8'h06);
                clear_pins();
            end
            lcdseq_pkg::FUNC_CLEAR: begin
                clear_pins();
            end
            lcdseq_pkg::FUNC_GOTO: begin
                // clamp the row, let the column wrap the address
                r = row;
                if (r < 3'd1) r = 3'd1;
                if (r > 3'(ROWS)) r = 3'(ROWS);
                addr = ROW_START[2'(r - 3'd1)] + 8'(column) - 8'd1;
                write_byte_pins(1'b0, addr);
                hold_pins(timing[lcdseq_pkg::H_GOTO]);
            end
            default: ;
        endcase
        if (expected_pins.size() > start_n) begin
            tail      = expected_pins.pop_back();
            tail.last = 1'b1;
            expected_pins.push_back(tail);
        end
    endtask

    function automatic int field_mismatch(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Track register writes, predict on request transfers, check pin-state transfers
    always @(posedge i_clk) begin : monitor
        t_pin_state want;
        if (!i_rst_n) begin
            timing[lcdseq_pkg::H_PULSE] = 16'd1000;
            timing[lcdseq_pkg::H_EXEC]  = 16'd300;
            timing[lcdseq_pkg::H_CLEAR] = 16'd15000;
            timing[lcdseq_pkg::H_GOTO]  = 16'd10000;
            timing[lcdseq_pkg::H_POWER] = 16'd15000;
            timing[lcdseq_pkg::H_WAKE1] = 16'd10000;
            timing[lcdseq_pkg::H_WAKE]  = 16'd150;
            expected_pins.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we && i_cfg_index < 3'(lcdseq_pkg::NREGS))
                timing[i_cfg_index] = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_pins.size() == 0) begin
                    $error("unexpected pin state: rs %0d en %0d nibble %0h hold %0d last %0d",
                           i_reg_select, i_enable_pin, i_nibble, i_hold_us, i_last);
                    o_fail_count++;
                end else begin
                    want = expected_pins.pop_front();
                    o_fail_count += field_mismatch("reg_select", 16'(want.rs), 16'(i_reg_select));
                    o_fail_count += field_mismatch("enable_pin", 16'(want.en), 16'(i_enable_pin));
                    o_fail_count += field_mismatch("nibble", 16'(want.nib), 16'(i_nibble));
                    o_fail_count += field_mismatch("hold_us", want.hold, i_hold_us);
                    o_fail_count += field_mismatch("last", 16'(want.last), 16'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_request(i_func, i_value, i_row, i_column);
        end
        o_pending = expected_pins.size();
    end

endmodule

// ----- tb/char_lcd_nibble_write_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_test
// Regression bench for the LCD write sequencer: directed requests covering
// every function and the odd row and column cases, then random requests
// under three timing settings and three idling patterns, with one long
// receiver hold-off. Checking is done by the checker placed beside the block.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_test;

    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         DRAIN_WAIT  = 8;
    localparam int         HOLD_OFF    = 400;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    typedef enum {TIMING_ZERO, TIMING_MAX, TIMING_RANDOM} t_timing_mode;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_index  = '0;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  req_func   = '0;
    logic [7:0]  req_value  = '0;
    logic [2:0]  req_row    = '0;
    logic [4:0]  req_column = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        pin_rs;
    logic        pin_en;
    logic [3:0]  pin_nibble;
    logic [15:0] pin_hold_us;
    logic        pin_last;

    int          fail_count;
    int          pending;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    logic        hold_done      = 1'b0;
    int          hold_left      = 0;
    int          cycle_count    = 0;

    char_lcd_nibble_write_sequencer dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (req_func),
        .i_value      (req_value),
        .i_row        (req_row),
        .i_column     (req_column),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_reg_select (pin_rs),
        .o_enable_pin (pin_en),
        .o_nibble     (pin_nibble),
        .o_hold_us    (pin_hold_us),
        .o_last       (pin_last)
    );

    char_lcd_nibble_write_sequencer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_func       (req_func),
        .i_value      (req_value),
        .i_row        (req_row),
        .i_column     (req_column),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_reg_select (pin_rs),
        .i_enable_pin (pin_en),
        .i_nibble     (pin_nibble),
        .i_hold_us    (pin_hold_us),
        .i_last       (pin_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("char_lcd_nibble_write_sequencer regression: fail");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off once requested
    always @(posedge clk) begin
        if (hold_request && !hold_done) begin
            hold_left = HOLD_OFF;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Offer one request and return at the edge where it transfers; valid stays high
    task automatic offer_request(input logic [2:0] func, input logic [7:0] value,
                                 input logic [2:0] row, input logic [4:0] column);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_func   <= func;
        req_value  <= value;
        req_row    <= row;
        req_column <= column;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
    endtask

    // Mostly legal requests, some rows and columns out of range, a few unknown functions
    task automatic random_request();
        int         pick;
        logic [2:0] func;
        logic [2:0] row;
        logic [4:0] column;
        pick = $urandom_range(0, 99);
        if (pick < 30)      func = lcdseq_pkg::FUNC_CMD;
        else if (pick < 55) func = lcdseq_pkg::FUNC_DATA;
        else if (pick < 63) func = lcdseq_pkg::FUNC_INIT;
        else if (pick < 73) func = lcdseq_pkg::FUNC_CLEAR;
        else if (pick < 93) func = lcdseq_pkg::FUNC_GOTO;
        else                func = 3'($urandom_range(5, 7));
        row    = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(1, 4))
                                              : 3'($urandom_range(0, 7));
        column = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(1, 20))
                                              : 5'($urandom_range(0, 31));
        offer_request(func, 8'($urandom_range(0, 255)), row, column);
    endtask

    // Drop valid, wait for every pin state to drain, then let the block go idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Load all timing registers, then poke the unused index
    task automatic program_timing(input t_timing_mode mode);
        logic [15:0] v;
        for (int i = 0; i < lcdseq_pkg::NREGS; i++) begin
            case (mode)
                TIMING_ZERO: v = 16'h0000;
                TIMING_MAX:  v = 16'hFFFF;
                default:     v = 16'($urandom_range(0, 65535));
            endcase
            write_reg(3'(i), v);
        end
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at reset timing: sender idles lightly, receiver heavily
        send_idle_pct  <= 26;
        recv_stall_pct <= 79;
        @(posedge clk);
        offer_request(lcdseq_pkg::FUNC_CMD,   8'h00, 3'd0, 5'd0);
        offer_request(lcdseq_pkg::FUNC_CMD,   8'hFF, 3'd7, 5'd31);
        offer_request(lcdseq_pkg::FUNC_DATA,  8'hA5, 3'd1, 5'd1);
        offer_request(lcdseq_pkg::FUNC_DATA,  8'h5A, 3'd2, 5'd10);
        offer_request(lcdseq_pkg::FUNC_INIT,  8'h00, 3'd0, 5'd0);
        offer_request(lcdseq_pkg::FUNC_CLEAR, 8'hFF, 3'd4, 5'd20);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd1, 5'd1);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd4, 5'd20);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd2, 5'd7);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd3, 5'd13);
        // row zero, rows above the display, column zero and past the end
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd0, 5'd5);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd7, 5'd31);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd2, 5'd0);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd5, 5'd0);
        offer_request(lcdseq_pkg::FUNC_GOTO,  8'h00, 3'd1, 5'd0);
        // unknown functions give nothing
        offer_request(3'd5, 8'h12, 3'd1, 5'd1);
        offer_request(3'd6, 8'h34, 3'd2, 5'd2);
        offer_request(3'd7, 8'hFF, 3'd7, 5'd31);
        offer_request(lcdseq_pkg::FUNC_DATA,  8'h41, 3'd1, 5'd1);
        settle();

        // Zero timings
        program_timing(TIMING_ZERO);
        repeat (90) random_request();
        settle();

        // Full-scale timings, sender idles heavily and receiver lightly
        send_idle_pct  <= 79;
        recv_stall_pct <= 26;
        program_timing(TIMING_MAX);
        repeat (90) random_request();
        settle();

        // Random timings, no idling, one long receiver hold-off
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        program_timing(TIMING_RANDOM);
        hold_request   <= 1'b1;
        repeat (84) random_request();
        settle();

        if (fail_count == 0 && pending == 0)
            $display("char_lcd_nibble_write_sequencer regression: pass");
        else
            $display("char_lcd_nibble_write_sequencer regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lcdseq_pkg.sv
rtl/core/lcdseq_cfg.sv
rtl/core/lcdseq_useq.sv
rtl/core/char_lcd_nibble_write_sequencer.sv
tb/char_lcd_nibble_write_sequencer_checker.sv
tb/char_lcd_nibble_write_sequencer_test.sv
